// File: hdl/pet_pkg.sv
// Shared types, token codes and keyword tables for the plural-forms tokenizer.
package pet_pkg;

  localparam int ValueWidth = 32;
  localparam int FifoDepth  = 4;

  typedef enum logic [4:0] {
    TK_END      = 5'd0,
    TK_NE       = 5'd1,
    TK_NOT      = 5'd2,
    TK_MOD      = 5'd3,
    TK_ANDAND   = 5'd4,
    TK_BITAND   = 5'd5,
    TK_LP       = 5'd6,
    TK_RP       = 5'd7,
    TK_MUL      = 5'd8,
    TK_PLUS     = 5'd9,
    TK_MINUS    = 5'd10,
    TK_DIV      = 5'd11,
    TK_INTEGER  = 5'd12,
    TK_COLON    = 5'd13,
    TK_SEMI     = 5'd14,
    TK_LE       = 5'd15,
    TK_LT       = 5'd16,
    TK_EQ       = 5'd17,
    TK_EQU      = 5'd18,
    TK_GE       = 5'd19,
    TK_GT       = 5'd20,
    TK_QUEST    = 5'd21,
    TK_NUMBER   = 5'd22,
    TK_NPLURALS = 5'd23,
    TK_PLURAL   = 5'd24,
    TK_JUNK     = 5'd25,
    TK_BITXOR   = 5'd26,
    TK_OROR     = 5'd27,
    TK_BITOR    = 5'd28,
    TK_BITNOT   = 5'd29
  } token_kind_e;

  typedef struct packed {
    token_kind_e kind;
    logic [31:0] value;
    logic        ovf;
    logic        last;
  } token_t;

  // "nplurals", indexed by character position
  function automatic logic [7:0] kw_long_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "n";
      3'd1:    ch = "p";
      3'd2:    ch = "l";
      3'd3:    ch = "u";
      3'd4:    ch = "r";
      3'd5:    ch = "a";
      3'd6:    ch = "l";
      3'd7:    ch = "s";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "plural"; positions past the end never match
  function automatic logic [7:0] kw_short_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "p";
      3'd1:    ch = "l";
      3'd2:    ch = "u";
      3'd3:    ch = "r";
      3'd4:    ch = "a";
      3'd5:    ch = "l";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: hdl/plural_expression_tokenizer.sv
// Top level: input register, lexer and token queue.
//
//   port group | dir | handshake                | payload
//   -----------+-----+--------------------------+--------------------------------------
//   in         | in  | in_valid_i / in_ready_o  | in_byte_i, end_of_text_i
//   out        | out | out_valid_o / out_ready_i| token_kind_o, int_value_o,
//              |     |                          | value_overflow_o, last_of_run_o
//
// One byte per cycle while the queue has room: a byte is held in the input register,
// is decoded and pushes zero, one or two tokens into a four-entry queue.
// The queue drains one token per cycle while out_ready_i is high, so bytes that close a
// token and emit another put two tokens in the queue; the input stalls while two slots are not free.
// The first token is offered once its byte has passed the input register and the lexer. Reset
// (async, low) returns the lexer to idle and empties the queue.
module plural_expression_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [31:0] int_value_o,
  output logic        value_overflow_o,
  output logic        last_of_run_o
);
  import pet_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       end_q;
  logic       room;
  logic       fire;
  token_t     tok0, tok1, tok_out;
  logic [1:0] num_tok;
  logic [1:0] push_cnt;

  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || fire;
  assign push_cnt   = fire ? num_tok : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      end_q  <= end_of_text_i;
    end
  end

  pet_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (byte_q),
    .end_i     (end_q),
    .tok0_o    (tok0),
    .tok1_o    (tok1),
    .num_tok_o (num_tok)
  );

  pet_token_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .tok0_i     (tok0),
    .tok1_i     (tok1),
    .has_room_o (room),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .tok_o      (tok_out)
  );

  assign token_kind_o     = tok_out.kind;
  assign int_value_o      = tok_out.value;
  assign value_overflow_o = tok_out.ovf;
  assign last_of_run_o    = tok_out.last;

endmodule

// File: hdl/pet_lexer.sv
// Lexer state and per-byte token decode; yields up to two tokens per item.
module pet_lexer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  input  logic            end_i,
  output pet_pkg::token_t tok0_o,
  output pet_pkg::token_t tok1_o,
  output logic [1:0]      num_tok_o
);
  import pet_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_OP   = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_ID   = 2'd3;

  localparam logic [2:0] OP_BANG = 3'd0;
  localparam logic [2:0] OP_AMP  = 3'd1;
  localparam logic [2:0] OP_LT   = 3'd2;
  localparam logic [2:0] OP_EQ   = 3'd3;
  localparam logic [2:0] OP_GT   = 3'd4;
  localparam logic [2:0] OP_BAR  = 3'd5;

  localparam int AccWideW = ValueWidth + 4;
  localparam logic [ValueWidth-1:0] AccMax = '1;

  logic [1:0]            mode_q, mode_d;
  logic [2:0]            pend_q, pend_d;
  logic [ValueWidth-1:0] acc_q, acc_d;
  logic                  sat_q, sat_d;
  logic [3:0]            id_len_q, id_len_d;
  logic [1:0]            cand_q, cand_d;

  logic                  is_end, is_digit, is_ident, cont;
  logic [7:0]            lc;
  logic [3:0]            digit;
  logic [AccWideW-1:0]   acc_wide;
  logic                  acc_over;
  logic                  pair_hit;
  token_kind_e           pair_kind, flush_kind, idle_kind;
  logic                  flush_has, idle_emit;
  logic [1:0]            cand_add;
  token_t                flush_tok, second_tok;
  logic                  second_has;

  assign is_end   = end_i || (byte_i == 8'h00);
  assign is_digit = byte_i inside {[8'h30:8'h39]};
  assign is_ident = (byte_i inside {[8'h41:8'h5a], [8'h61:8'h7a]}) || (byte_i == 8'h5f);
  assign lc       = (byte_i inside {[8'h41:8'h5a]}) ? byte_i + 8'd32 : byte_i;
  assign digit    = byte_i[3:0];

  assign acc_wide = (AccWideW'(acc_q) << 3) + (AccWideW'(acc_q) << 1) + AccWideW'(digit);
  assign acc_over = acc_wide[AccWideW-1:ValueWidth] != '0;

  // keyword tracking for the byte joining an open identifier
  always_comb begin
    cand_add = cand_q;
    if (!(id_len_q < 4'd8 && lc == kw_long_char(id_len_q[2:0])))
      cand_add[0] = 1'b0;
    if (!(id_len_q < 4'd6 && lc == kw_short_char(id_len_q[2:0])))
      cand_add[1] = 1'b0;
  end

  always_comb begin
    pair_hit  = 1'b1;
    pair_kind = TK_JUNK;
    if (pend_q == OP_BANG && byte_i == "=")     pair_kind = TK_NE;
    else if (pend_q == OP_AMP && byte_i == "&") pair_kind = TK_ANDAND;
    else if (pend_q == OP_LT && byte_i == "=")  pair_kind = TK_LE;
    else if (pend_q == OP_LT && byte_i == ">")  pair_kind = TK_NE;
    else if (pend_q == OP_EQ && byte_i == "=")  pair_kind = TK_EQ;
    else if (pend_q == OP_GT && byte_i == "=")  pair_kind = TK_GE;
    else if (pend_q == OP_BAR && byte_i == "|") pair_kind = TK_OROR;
    else pair_hit = 1'b0;
  end

  // token that closes the open one
  always_comb begin
    flush_has  = mode_q != MODE_IDLE;
    flush_kind = TK_JUNK;
    case (mode_q)
      MODE_OP: begin
        case (pend_q)
          OP_BANG: flush_kind = TK_NOT;
          OP_AMP:  flush_kind = TK_BITAND;
          OP_LT:   flush_kind = TK_LT;
          OP_EQ:   flush_kind = TK_EQU;
          OP_GT:   flush_kind = TK_GT;
          OP_BAR:  flush_kind = TK_BITOR;
          default: flush_kind = TK_JUNK;
        endcase
      end
      MODE_NUM: flush_kind = TK_INTEGER;
      MODE_ID: begin
        if (cand_q[0] && id_len_q == 4'd1)      flush_kind = TK_NUMBER;
        else if (cand_q[0] && id_len_q == 4'd8) flush_kind = TK_NPLURALS;
        else if (cand_q[1] && id_len_q == 4'd6) flush_kind = TK_PLURAL;
        else                                    flush_kind = TK_JUNK;
      end
      default: flush_kind = TK_JUNK;
    endcase
    flush_tok.kind  = flush_kind;
    flush_tok.value = (mode_q == MODE_NUM) ? 32'(acc_q) : 32'd0;
    flush_tok.ovf   = (mode_q == MODE_NUM) ? sat_q : 1'b0;
    flush_tok.last  = 1'b0;
  end

  // end of text always closes the open token, whatever the byte holds
  assign cont = !is_end &&
                ((mode_q == MODE_OP && pair_hit) || (mode_q == MODE_NUM && is_digit) ||
                 (mode_q == MODE_ID && (is_ident || is_digit)));

  // byte not continuing an open token: single-char token, start of a new one, or none for space
  always_comb begin
    idle_emit = 1'b0;
    idle_kind = TK_JUNK;
    case (byte_i)
      " ", 8'h09, 8'h0a, 8'h0c: idle_emit = 1'b0;
      "!", "&", "<", "=", ">", "|": idle_emit = 1'b0;
      "%": begin idle_emit = 1'b1; idle_kind = TK_MOD;    end
      "(": begin idle_emit = 1'b1; idle_kind = TK_LP;     end
      ")": begin idle_emit = 1'b1; idle_kind = TK_RP;     end
      "*": begin idle_emit = 1'b1; idle_kind = TK_MUL;    end
      "+": begin idle_emit = 1'b1; idle_kind = TK_PLUS;   end
      "-": begin idle_emit = 1'b1; idle_kind = TK_MINUS;  end
      "/": begin idle_emit = 1'b1; idle_kind = TK_DIV;    end
      ":": begin idle_emit = 1'b1; idle_kind = TK_COLON;  end
      ";": begin idle_emit = 1'b1; idle_kind = TK_SEMI;   end
      "?": begin idle_emit = 1'b1; idle_kind = TK_QUEST;  end
      "^": begin idle_emit = 1'b1; idle_kind = TK_BITXOR; end
      "~": begin idle_emit = 1'b1; idle_kind = TK_BITNOT; end
      default: begin
        idle_emit = !(is_digit || is_ident);
        idle_kind = TK_JUNK;
      end
    endcase
  end

  always_comb begin
    mode_d     = mode_q;
    pend_d     = pend_q;
    acc_d      = acc_q;
    sat_d      = sat_q;
    id_len_d   = id_len_q;
    cand_d     = cand_q;
    second_has = 1'b0;
    second_tok = '{kind: TK_END, value: 32'd0, ovf: 1'b0, last: 1'b1};

    if (is_end) begin
      mode_d     = MODE_IDLE;
      second_has = 1'b1;
    end else if (cont) begin
      case (mode_q)
        MODE_OP: begin
          mode_d          = MODE_IDLE;
          second_has      = 1'b1;
          second_tok.kind = pair_kind;
        end
        MODE_NUM: begin
          if (sat_q || acc_over) begin
            acc_d = AccMax;
            sat_d = 1'b1;
          end else begin
            acc_d = acc_wide[ValueWidth-1:0];
          end
        end
        default: begin
          cand_d = cand_add;
          if (id_len_q != 4'hf) id_len_d = id_len_q + 4'd1;
        end
      endcase
    end else begin
      mode_d = MODE_IDLE;
      if (is_digit) begin
        mode_d = MODE_NUM;
        acc_d  = ValueWidth'(digit);
        sat_d  = 1'b0;
      end else if (is_ident) begin
        mode_d   = MODE_ID;
        id_len_d = 4'd1;
        cand_d   = {lc == kw_short_char(3'd0), lc == kw_long_char(3'd0)};
      end else begin
        case (byte_i)
          "!": begin mode_d = MODE_OP; pend_d = OP_BANG; end
          "&": begin mode_d = MODE_OP; pend_d = OP_AMP;  end
          "<": begin mode_d = MODE_OP; pend_d = OP_LT;   end
          "=": begin mode_d = MODE_OP; pend_d = OP_EQ;   end
          ">": begin mode_d = MODE_OP; pend_d = OP_GT;   end
          "|": begin mode_d = MODE_OP; pend_d = OP_BAR;  end
          default: mode_d = MODE_IDLE;
        endcase
      end
      second_has      = idle_emit;
      second_tok.kind = idle_kind;
    end
  end

  // pair up the closing token and the new one; the later one carries last
  always_comb begin
    logic use_flush;
    use_flush = flush_has && !cont;
    tok1_o    = second_tok;
    if (use_flush && second_has) begin
      tok0_o    = flush_tok;
      num_tok_o = 2'd2;
    end else if (use_flush) begin
      tok0_o      = flush_tok;
      tok0_o.last = 1'b1;
      num_tok_o   = 2'd1;
    end else begin
      tok0_o    = second_tok;
      num_tok_o = second_has ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pend_q   <= '0;
      acc_q    <= '0;
      sat_q    <= 1'b0;
      id_len_q <= '0;
      cand_q   <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      acc_q    <= acc_d;
      sat_q    <= sat_d;
      id_len_q <= id_len_d;
      cand_q   <= cand_d;
    end
  end

  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_end |=> mode_q == MODE_IDLE)
    else $error("lexer not idle after end of text");

  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_end |-> num_tok_o != 2'd0)
    else $error("end of text produced no token");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && num_tok_o == 2'd2 |-> !tok0_o.last && tok1_o.last)
    else $error("last flag misplaced on a token pair");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> acc_q == AccMax)
    else $error("saturated integer not at maximum");

endmodule

// File: hdl/pet_token_fifo.sv
// Four-entry token queue taking up to two tokens per cycle, one out per cycle while ready_i is high.
module pet_token_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_cnt_i,
  input  pet_pkg::token_t tok0_i,
  input  pet_pkg::token_t tok1_i,
  output logic            has_room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output pet_pkg::token_t tok_o
);
  import pet_pkg::*;

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = PtrW + 1;

  token_t            mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_q, rd_q, wr_d, rd_d, wr_next;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = cnt_q != '0;
  assign has_room_o = cnt_q <= CntW'(FifoDepth - 2);
  assign tok_o      = mem_q[rd_q];
  assign wr_next    = wr_q + PtrW'(1);

  always_comb begin
    wr_d  = wr_q + PtrW'(push_cnt_i);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= tok0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_next] <= tok1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("token queue over capacity");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> has_room_o)
    else $error("push into queue without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PtrW'(wr_q - rd_q) == cnt_q[PtrW-1:0])
    else $error("queue pointers disagree with count");

endmodule
